// ===== src/dns_soa_pkg.sv =====
// ----------------------------------------------------------------------------
// dns_soa_pkg
// Types and constants shared by the DNS authority record TTL parser.
// ----------------------------------------------------------------------------
package dns_soa_pkg;

    // Parser phase within one message.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_LABEL  = 3'd2,
        PH_PTR    = 3'd3,
        PH_FIXED  = 3'd4,
        PH_RDATA  = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_BAD_MSG  = 2'd2
    } t_status;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] ttl;
    } t_result;

    // Message layout constants.
    localparam logic [3:0] HEADER_LAST_IDX = 4'd11;
    localparam logic [3:0] QDCOUNT_IDX     = 4'd5;
    localparam logic [3:0] ANCOUNT_IDX     = 4'd7;
    localparam logic [3:0] NSCOUNT_IDX     = 4'd9;
    localparam logic [3:0] QFIXED_LAST_IDX = 4'd3;
    localparam logic [3:0] RR_TYPE_END_IDX = 4'd2;
    localparam logic [3:0] RR_TTL_IDX      = 4'd4;
    localparam logic [3:0] RR_RDLEN_IDX    = 4'd8;
    localparam logic [3:0] RR_FIXED_LAST   = 4'd9;
    localparam logic [7:0] PTR_MASK        = 8'hC0;

    // Configuration register map.
    localparam logic REG_TARGET_TYPE = 1'b0;
    localparam logic [15:0] TARGET_TYPE_RESET = 16'd6;

endpackage

// ===== src/dns_soa_parser.sv =====
// ----------------------------------------------------------------------------
// dns_soa_parser
// Byte-serial DNS message walker. Holds the parse state and produces one
// result on the byte marked last, combinationally from the accepted byte.
// ----------------------------------------------------------------------------
module dns_soa_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_msg_byte,
    input  logic                 i_last,
    input  logic [15:0]          i_target_type,
    output logic                 o_res_valid,
    output dns_soa_pkg::t_result o_res
);

    dns_soa_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_label_remaining, n_label_remaining;
    logic [15:0] r_header_shift, n_header_shift;
    logic [15:0] r_questions_left, n_questions_left;
    logic [15:0] r_answers_left, n_answers_left;
    logic [15:0] r_authority_left, n_authority_left;
    logic [15:0] r_record_type, n_record_type;
    logic [31:0] r_record_ttl, n_record_ttl;
    logic [15:0] r_rdata_left, n_rdata_left;
    logic        r_matched, n_matched;
    logic [31:0] r_matched_ttl, n_matched_ttl;
    logic        finish;

    // Next state for one accepted byte.
    always_comb begin
        n_phase           = r_phase;
        n_byte_index      = r_byte_index;
        n_label_remaining = r_label_remaining;
        n_header_shift    = r_header_shift;
        n_questions_left  = r_questions_left;
        n_answers_left    = r_answers_left;
        n_authority_left  = r_authority_left;
        n_record_type     = r_record_type;
        n_record_ttl      = r_record_ttl;
        n_rdata_left      = r_rdata_left;
        n_matched         = r_matched;
        n_matched_ttl     = r_matched_ttl;
        finish            = 1'b0;

        case (r_phase)
            dns_soa_pkg::PH_HEADER: begin
                n_header_shift = {r_header_shift[7:0], i_msg_byte};
                if (r_byte_index == dns_soa_pkg::QDCOUNT_IDX) begin
                    n_questions_left = n_header_shift;
                end
                if (r_byte_index == dns_soa_pkg::ANCOUNT_IDX) begin
                    n_answers_left = n_header_shift;
                end
                if (r_byte_index == dns_soa_pkg::NSCOUNT_IDX) begin
                    n_authority_left = n_header_shift;
                end
                if (r_byte_index >= dns_soa_pkg::HEADER_LAST_IDX) begin
                    n_byte_index = '0;
                    if (n_questions_left != '0 || n_answers_left != '0 ||
                        n_authority_left != '0) begin
                        n_phase = dns_soa_pkg::PH_NAME;
                    end else begin
                        n_phase = dns_soa_pkg::PH_DONE;
                    end
                end else begin
                    n_byte_index = r_byte_index + 4'd1;
                end
            end
            dns_soa_pkg::PH_NAME: begin
                if ((i_msg_byte & dns_soa_pkg::PTR_MASK) == dns_soa_pkg::PTR_MASK) begin
                    n_phase = dns_soa_pkg::PH_PTR;
                end else if (i_msg_byte == 8'd0) begin
                    n_phase      = dns_soa_pkg::PH_FIXED;
                    n_byte_index = '0;
                end else begin
                    n_label_remaining = i_msg_byte;
                    n_phase           = dns_soa_pkg::PH_LABEL;
                end
            end
            dns_soa_pkg::PH_LABEL: begin
                n_label_remaining = r_label_remaining - 8'd1;
                if (n_label_remaining == 8'd0) begin
                    n_phase = dns_soa_pkg::PH_NAME;
                end
            end
            dns_soa_pkg::PH_PTR: begin
                n_phase      = dns_soa_pkg::PH_FIXED;
                n_byte_index = '0;
            end
            dns_soa_pkg::PH_FIXED: begin
                if (r_questions_left != '0) begin
                    // Question: type and class only.
                    if (r_byte_index >= dns_soa_pkg::QFIXED_LAST_IDX) begin
                        finish = 1'b1;
                    end else begin
                        n_byte_index = r_byte_index + 4'd1;
                    end
                end else begin
                    // Resource record: type, class, TTL, rdata length.
                    if (r_byte_index < dns_soa_pkg::RR_TYPE_END_IDX) begin
                        n_record_type = {r_record_type[7:0], i_msg_byte};
                    end else if (r_byte_index >= dns_soa_pkg::RR_TTL_IDX &&
                                 r_byte_index < dns_soa_pkg::RR_RDLEN_IDX) begin
                        n_record_ttl = {r_record_ttl[23:0], i_msg_byte};
                    end else if (r_byte_index >= dns_soa_pkg::RR_RDLEN_IDX) begin
                        n_rdata_left = {r_rdata_left[7:0], i_msg_byte};
                    end
                    if (r_byte_index >= dns_soa_pkg::RR_FIXED_LAST) begin
                        if (n_rdata_left == '0) begin
                            finish = 1'b1;
                        end else begin
                            n_phase = dns_soa_pkg::PH_RDATA;
                        end
                    end else begin
                        n_byte_index = r_byte_index + 4'd1;
                    end
                end
            end
            dns_soa_pkg::PH_RDATA: begin
                n_rdata_left = r_rdata_left - 16'd1;
                if (n_rdata_left == '0) begin
                    finish = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // End of a record: count it down, or for an authority record check for a match, and move on.
        if (finish) begin
            if (r_questions_left != '0) begin
                n_questions_left = r_questions_left - 16'd1;
            end else if (r_answers_left != '0) begin
                n_answers_left = r_answers_left - 16'd1;
            end else if (n_record_type == i_target_type) begin
                n_matched     = 1'b1;
                n_matched_ttl = n_record_ttl;
            end else begin
                n_authority_left = r_authority_left - 16'd1;
            end
            n_byte_index = '0;
            if (n_matched) begin
                n_phase = dns_soa_pkg::PH_DONE;
            end else if (n_questions_left != '0 || n_answers_left != '0 ||
                         n_authority_left != '0) begin
                n_phase = dns_soa_pkg::PH_NAME;
            end else begin
                n_phase = dns_soa_pkg::PH_DONE;
            end
        end
    end

    // Result for the byte marked last.
    always_comb begin
        o_res_valid = i_accept && i_last;
        if (n_matched) begin
            o_res.status = dns_soa_pkg::STATUS_FOUND;
            o_res.ttl    = n_matched_ttl;
        end else if (n_phase == dns_soa_pkg::PH_DONE) begin
            o_res.status = dns_soa_pkg::STATUS_NO_MATCH;
            o_res.ttl    = '0;
        end else begin
            o_res.status = dns_soa_pkg::STATUS_BAD_MSG;
            o_res.ttl    = '0;
        end
    end

    // State registers; the last byte returns everything to the message start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase           <= dns_soa_pkg::PH_HEADER;
            r_byte_index      <= '0;
            r_label_remaining <= '0;
            r_header_shift    <= '0;
            r_questions_left  <= '0;
            r_answers_left    <= '0;
            r_authority_left  <= '0;
            r_record_type     <= '0;
            r_record_ttl      <= '0;
            r_rdata_left      <= '0;
            r_matched         <= 1'b0;
            r_matched_ttl     <= '0;
        end else if (i_accept) begin
            r_phase           <= n_phase;
            r_byte_index      <= n_byte_index;
            r_label_remaining <= n_label_remaining;
            r_header_shift    <= n_header_shift;
            r_questions_left  <= n_questions_left;
            r_answers_left    <= n_answers_left;
            r_authority_left  <= n_authority_left;
            r_record_type     <= n_record_type;
            r_record_ttl      <= n_record_ttl;
            r_rdata_left      <= n_rdata_left;
            r_matched         <= n_matched;
            r_matched_ttl     <= n_matched_ttl;
        end
    end

endmodule

// ===== src/dns_authority_soa_ttl_parser.sv =====
// ----------------------------------------------------------------------------
// dns_authority_soa_ttl_parser
// Finds the first authority record of a configured type in a DNS message
// and reports its TTL.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock cycle, header first, and can
// accept a byte in every cycle unless stalled. Each accepted byte updates the
// parse state; on the byte marked last the result (status and TTL) goes into
// a two-entry output buffer: the output register, or the skid register while
// the output holds a result not yet taken. Input is stalled only when two
// results are waiting to be taken. The type searched for is written through
// the APB port at byte address 0 and resets to 6 (SOA).
// ----------------------------------------------------------------------------
module dns_authority_soa_ttl_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Message byte input.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_last,
    // Result output.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_ttl
);

    logic [15:0]          r_target_type;
    logic                 accept;
    logic                 push;
    logic                 pop;
    dns_soa_pkg::t_result res;
    dns_soa_pkg::t_result r_out, r_skid;
    logic                 r_out_valid, r_skid_valid;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_type <= dns_soa_pkg::TARGET_TYPE_RESET;
        end else if (psel && penable && pwrite &&
                     paddr[2] == dns_soa_pkg::REG_TARGET_TYPE) begin
            r_target_type <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == dns_soa_pkg::REG_TARGET_TYPE) ?
                    {16'd0, r_target_type} : 32'd0;

    // Parser core.
    assign accept = i_in_valid && !o_in_stall;

    dns_soa_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_msg_byte    (i_msg_byte),
        .i_last        (i_last),
        .i_target_type (r_target_type),
        .o_res_valid   (push),
        .o_res         (res)
    );

    // Two-entry output buffer: output register plus skid register.
    assign pop        = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= push;
            end else begin
                r_out_valid  <= push;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out  <= res;
            end
        end else if (push) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_ttl       = r_out.ttl;

endmodule
